// ===== rtl/clsr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_pkg
// Shared constants and controller/datapath command and status types for the
// combined congruential generator with shuffle table.
// ----------------------------------------------------------------------------
package clsr_pkg;

    localparam int unsigned VAL_W          = 31;
    localparam int unsigned TABLE_SIZE_DEF = 32;
    localparam int unsigned EXTRA_WARMUP   = 8;

    localparam logic [30:0] MOD_ONE        = 31'd2147483563;
    localparam logic [30:0] MOD_TWO        = 31'd2147483399;
    localparam logic [15:0] MUL_ONE        = 16'd40014;
    localparam logic [15:0] MUL_TWO        = 16'd40692;
    // 2^31 minus each modulus, used to fold the high product bits back in.
    localparam logic [7:0]  FOLD_ONE       = 8'd85;
    localparam logic [7:0]  FOLD_TWO       = 8'd249;
    localparam logic [30:0] WRAP_ADD       = 31'd2147483562;
    localparam logic [30:0] DEFAULT_SECOND = 31'd123456789;

    typedef struct packed {
        logic seed_load;
        logic warm_step;
        logic div_load;
        logic gen_step;
        logic ram_read;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic warm_done;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/combined_lcg_shuffle_rng.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Combined two-generator congruential random number source with a shuffle
// table.
//
// The input channel takes one item at a time: a draw, or a reseed followed
// by a draw. Each item gives exactly one result on the output channel.
// A draw is accepted, then runs through the slot computation, the generator
// step and the table read before its result is written; the block takes no
// new item until the current one is finished, for any table size.
// The slot comes from one reciprocal multiplication of the previous result,
// and each generator step passes through a two-register multiply and
// modular reduction pipeline.
// A reseed adds warm-up steps before its draw, of which only the last
// TABLE_SIZE also write the table.
// Reset restores both generators to their start values and marks every
// table entry as reading zero; no clearing pass is needed.
// A stalled result holds in the output register while the next item is
// accepted and worked on; that item's result waits until the register frees.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng
    import clsr_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [30:0] i_seed_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [30:0] o_random_value
);

    t_cmd    cmd;
    t_status status;

    clsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    clsr_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_seed_value   (i_seed_value),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_random_value (o_random_value)
    );

endmodule
`default_nettype wire

// ===== rtl/clsr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module clsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/clsr_lcg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_lcg
// One multiplicative congruential step, z * MUL mod MODV, as a free-running
// pipeline: multiply, fold the high bits, then one compare and subtract.
// ----------------------------------------------------------------------------
module clsr_lcg
    import clsr_pkg::*;
#(
    parameter logic [15:0] MUL  = MUL_ONE,
    parameter logic [30:0] MODV = MOD_ONE,
    parameter logic [7:0]  FOLD = FOLD_ONE
) (
    input  wire logic        i_clk,
    input  wire logic [30:0] i_z,
    output logic      [30:0] o_next
);

    logic [46:0] r_prod;
    logic [46:0] n_prod;
    logic [31:0] r_fold;
    logic [31:0] n_fold;

    always_comb begin
        n_prod = {16'd0, i_z} * {31'd0, MUL};
        n_fold = {1'b0, r_prod[30:0]} + ({16'd0, r_prod[46:31]} * {24'd0, FOLD});
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_fold <= n_fold;
    end

    // The folded sum stays below twice the modulus.
    assign o_next = (r_fold >= {1'b0, MODV}) ? 31'(r_fold - {1'b0, MODV}) : r_fold[30:0];

endmodule
`default_nettype wire

// ===== rtl/clsr_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_dp
// Datapath: both generators, the shuffle table with its valid bits, the
// reciprocal slot multiplier and the output register.
// ----------------------------------------------------------------------------
module clsr_dp
    import clsr_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    input  wire logic [30:0] i_seed_value,
    input  wire logic        i_out_stall,
    output logic             o_out_valid,
    output logic      [30:0] o_random_value
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int SW = $clog2(TABLE_SIZE + EXTRA_WARMUP);
    localparam logic [30:0] SLOT_DIV = 31'(32'd1 + {1'b0, WRAP_ADD} / 32'(TABLE_SIZE));
    // The rounded-up reciprocal gives the exact quotient for any 31-bit dividend.
    localparam int RS = 31 + $clog2(SLOT_DIV);
    localparam logic [31:0] SLOT_RECIP =
        32'(((64'd1 << RS) + 64'(SLOT_DIV) - 64'd1) / 64'(SLOT_DIV));

    logic [30:0]         r_gen1, n_gen1;
    logic [30:0]         r_gen2, n_gen2;
    logic [30:0]         r_last, n_last;
    logic [SW-1:0]       r_step, n_step;
    logic [AW-1:0]       r_q, n_q;
    logic [TABLE_SIZE-1:0] r_valid, n_valid;
    logic                r_rd_valid, n_rd_valid;
    logic [30:0]         r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [30:0]   lcg1_next;
    logic [30:0]   lcg2_next;
    logic [30:0]   seed_fix;
    logic [AW-1:0] slot;
    logic [62:0]   recip_prod;
    logic [62:0]   quot_full;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [30:0]   ram_wdata;
    logic [30:0]   ram_rdata;
    logic [30:0]   table_val;
    logic [31:0]   diff_raw;
    logic [31:0]   diff_fix;
    logic [30:0]   draw_val;

    clsr_lcg #(.MUL(MUL_ONE), .MODV(MOD_ONE), .FOLD(FOLD_ONE)) u_lcg1 (
        .i_clk  (i_clk),
        .i_z    (r_gen1),
        .o_next (lcg1_next)
    );

    clsr_lcg #(.MUL(MUL_TWO), .MODV(MOD_TWO), .FOLD(FOLD_TWO)) u_lcg2 (
        .i_clk  (i_clk),
        .i_z    (r_gen2),
        .o_next (lcg2_next)
    );

    clsr_ram #(.WIDTH(31), .DEPTH(TABLE_SIZE)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.ram_read),
        .i_raddr (slot),
        .o_rdata (ram_rdata)
    );

    assign seed_fix = (i_seed_value == '0) ? 31'd1 : i_seed_value;
    assign slot     = r_q;

    always_comb begin
        recip_prod = {32'd0, r_last} * {31'd0, SLOT_RECIP};
        quot_full  = recip_prod >> RS;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot;
        ram_wdata = r_gen1;
        if (i_cmd.warm_step) begin
            ram_we    = (r_step < SW'(TABLE_SIZE));
            ram_waddr = r_step[AW-1:0];
            ram_wdata = lcg1_next;
        end else if (i_cmd.finish) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        table_val = r_rd_valid ? ram_rdata : '0;
        diff_raw  = {1'b0, table_val} - {1'b0, r_gen2};
        diff_fix  = (diff_raw[31] || diff_raw == '0) ? diff_raw + {1'b0, WRAP_ADD}
                                                     : diff_raw;
        draw_val  = diff_fix[30:0];
    end

    always_comb begin
        n_gen1      = r_gen1;
        n_gen2      = r_gen2;
        n_last      = r_last;
        n_step      = r_step;
        n_q         = r_q;
        n_valid     = r_valid;
        n_rd_valid  = r_rd_valid;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.seed_load) begin
            n_gen1 = seed_fix;
            n_gen2 = seed_fix;
            n_step = SW'(TABLE_SIZE + EXTRA_WARMUP - 1);
        end
        if (i_cmd.warm_step) begin
            n_gen1 = lcg1_next;
            n_last = lcg1_next;
            n_step = SW'(r_step - 1'b1);
        end
        if (i_cmd.div_load) begin
            n_q = (quot_full > 63'(TABLE_SIZE - 1)) ? AW'(TABLE_SIZE - 1)
                                                    : quot_full[AW-1:0];
        end
        if (i_cmd.gen_step) begin
            n_gen1 = lcg1_next;
            n_gen2 = lcg2_next;
        end
        if (i_cmd.ram_read) begin
            n_rd_valid = r_valid[slot];
        end
        if (i_cmd.finish) begin
            n_last      = draw_val;
            n_out       = draw_val;
            n_out_valid = 1'b1;
        end
        if (ram_we) begin
            n_valid[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen1      <= 31'd1;
            r_gen2      <= DEFAULT_SECOND;
            r_last      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_gen1      <= n_gen1;
            r_gen2      <= n_gen2;
            r_last      <= n_last;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_q        <= n_q;
        r_rd_valid <= n_rd_valid;
        r_out      <= n_out;
    end

    assign o_status       = '{warm_done: (r_step == '0),
                              out_busy:  (r_out_valid && i_out_stall)};
    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out;

endmodule
`default_nettype wire

// ===== rtl/clsr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_ctrl
// Controller: sequences the warm-up steps, the slot computation, the
// generator step, the table read and the final write of each item.
// ----------------------------------------------------------------------------
module clsr_ctrl
    import clsr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_req_type,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_in_stall
);

    localparam int CW = 2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WARM = 5'b00010,
        S_DRAW = 5'b00100,
        S_READ = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cnt = '0;
                    if (i_req_type) begin
                        o_cmd.seed_load = 1'b1;
                        n_state         = S_WARM;
                    end else begin
                        n_state = S_DRAW;
                    end
                end
            end
            S_WARM: begin
                if (r_cnt == CW'(2)) begin
                    o_cmd.warm_step = 1'b1;
                    n_cnt           = '0;
                    if (i_status.warm_done) begin
                        n_state = S_DRAW;
                    end
                end else begin
                    n_cnt = CW'(r_cnt + 1'b1);
                end
            end
            S_DRAW: begin
                if (r_cnt == '0) begin
                    o_cmd.div_load = 1'b1;
                end
                if (r_cnt == CW'(2)) begin
                    o_cmd.gen_step = 1'b1;
                    n_state        = S_READ;
                end else begin
                    n_cnt = CW'(r_cnt + 1'b1);
                end
            end
            S_READ: begin
                o_cmd.ram_read = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;

endmodule
`default_nettype wire

// ===== rtl/clsr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_checker
// Port-level checks on the handshake, result range and busy period.
// ----------------------------------------------------------------------------
module clsr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_req_type,
    input wire logic [30:0] i_seed_value,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [30:0] o_random_value
);

    logic in_accept;

    assign in_accept = i_in_valid && !o_in_stall;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> $stable(i_req_type) && $stable(i_seed_value))
        else $error("Stalled input item changed.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_random_value))
        else $error("Stalled result changed or dropped.");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_random_value != 31'd0) && (o_random_value <= 31'd2147483562))
        else $error("Result out of range.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("Block took a new item too early.");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("Result appeared without an item in work.");

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_req_type     (i_req_type),
    .i_seed_value   (i_seed_value),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_random_value (o_random_value)
);
`default_nettype wire
